/* src/hsl_pkg.sv */
// Types and constants shared by the two-wire handshake byte link.
package hsl_pkg;

  localparam int unsigned TIMEOUT_W     = 24;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 24'd1000000;

  localparam logic [7:0]  TX_MARK = 8'h80;
  localparam logic [15:0] RX_MARK = 16'h8000;

  typedef enum logic [2:0] {
    MODE_TIP    = 3'd0,
    MODE_RING   = 3'd1,
    MODE_SEND   = 3'd2,
    MODE_ACCEPT = 3'd3,
    MODE_TICK   = 3'd4
  } mode_t;

  typedef enum logic [3:0] {
    PH_IDLE       = 4'd0,
    PH_WAIT_ACK_0 = 4'd1,
    PH_WAIT_ACK_1 = 4'd2,
    PH_WAIT_REL_0 = 4'd3,
    PH_WAIT_REL_1 = 4'd4,
    PH_ACK_0      = 4'd5,
    PH_ACK_1      = 4'd6,
    PH_HOLD_0     = 4'd7,
    PH_HOLD_1     = 4'd8,
    PH_WAIT_IDLE  = 4'd9
  } phase_t;

  typedef enum logic [1:0] {
    PB_EMPTY = 2'd0,
    PB_ZERO  = 2'd1,
    PB_ONE   = 2'd2
  } pend_t;

  typedef enum logic [2:0] {
    EV_NONE       = 3'd0,
    EV_RX         = 3'd1,
    EV_SENT       = 3'd2,
    EV_COLLISION  = 3'd3,
    EV_TX_TIMEOUT = 3'd4,
    EV_RX_TIMEOUT = 3'd5,
    EV_BAD_ACCEPT = 3'd6
  } event_t;

  typedef struct packed {
    phase_t                 phase;
    pend_t                  pend;
    logic                   tip_seen;
    logic                   ring_seen;
    logic                   tip_out;
    logic                   ring_out;
    logic [7:0]             tx_shift;
    logic [15:0]            rx_shift;
    logic [TIMEOUT_W-1:0]   timer_count;
    logic                   timer_on;
  } hsl_state_t;

  localparam hsl_state_t ST_RESET = '{
    phase:       PH_IDLE,
    pend:        PB_EMPTY,
    tip_seen:    1'b1,
    ring_seen:   1'b1,
    tip_out:     1'b1,
    ring_out:    1'b1,
    tx_shift:    8'h00,
    rx_shift:    16'h0000,
    timer_count: '0,
    timer_on:    1'b0
  };

  typedef struct packed {
    logic       tip_drive;
    logic       ring_drive;
    event_t     event_res;
    logic [7:0] rx_data;
    logic       overrun;
  } hsl_res_t;

endpackage

/* src/hsl_step.sv */
// Next-state and result logic for one link transaction.
module hsl_step (
  input  hsl_pkg::hsl_state_t           st,
  input  logic [2:0]                    mode,
  input  logic                          level,
  input  logic [7:0]                    tx_data,
  input  logic [hsl_pkg::TIMEOUT_W-1:0] timeout_ticks,
  output hsl_pkg::hsl_state_t           st_next,
  output hsl_pkg::hsl_res_t             res
);
  import hsl_pkg::*;

  function automatic void timer_start(inout hsl_state_t s, input logic [TIMEOUT_W-1:0] to);
    s.timer_count = to;
    s.timer_on = 1'b1;
  endfunction

  function automatic void timer_stop(inout hsl_state_t s);
    s.timer_count = '0;
    s.timer_on = 1'b0;
  endfunction

  function automatic void timer_idle_wait(inout hsl_state_t s,
                                          input logic [TIMEOUT_W-1:0] to);
    if (s.pend == PB_EMPTY) begin
      timer_stop(s);
    end else begin
      timer_start(s, to);
    end
  endfunction

  function automatic void start_pending(inout hsl_state_t s,
                                        input logic [TIMEOUT_W-1:0] to);
    if (s.pend == PB_ZERO) begin
      timer_start(s, to);
      s.phase = PH_WAIT_ACK_0;
      s.pend = PB_EMPTY;
      s.tip_out = 1'b0;
    end else if (s.pend == PB_ONE) begin
      timer_start(s, to);
      s.phase = PH_WAIT_ACK_1;
      s.pend = PB_EMPTY;
      s.ring_out = 1'b0;
    end else begin
      timer_stop(s);
      s.phase = PH_IDLE;
      s.pend = PB_EMPTY;
    end
  endfunction

  function automatic void queue_bit(inout hsl_state_t s, input logic b,
                                    input logic [TIMEOUT_W-1:0] to);
    s.pend = b ? PB_ONE : PB_ZERO;
    if (s.phase == PH_IDLE) begin
      start_pending(s, to);
    end else if (s.phase == PH_WAIT_IDLE) begin
      timer_start(s, to);
    end
  endfunction

  function automatic void lost_sync(inout hsl_state_t s, inout event_t ev,
                                    input logic [TIMEOUT_W-1:0] to);
    timer_idle_wait(s, to);
    s.phase = PH_WAIT_IDLE;
    s.tx_shift = '0;
    s.rx_shift = '0;
    ev = EV_COLLISION;
  endfunction

  function automatic void bit_done(inout hsl_state_t s, inout event_t ev,
                                   input logic [TIMEOUT_W-1:0] to);
    logic b;
    b = s.tx_shift[0];
    s.tx_shift = s.tx_shift >> 1;
    if (s.tx_shift != '0) begin
      queue_bit(s, b, to);
    end else begin
      ev = EV_SENT;
    end
  endfunction

  function automatic void accept_held(inout hsl_state_t s, inout event_t ev,
                                      input logic [TIMEOUT_W-1:0] to);
    if (s.phase == PH_HOLD_0) begin
      s.ring_out = 1'b1;
      if (s.ring_seen) begin
        start_pending(s, to);
      end else begin
        lost_sync(s, ev, to);
      end
    end else if (s.phase == PH_HOLD_1) begin
      s.tip_out = 1'b1;
      if (s.tip_seen) begin
        start_pending(s, to);
      end else begin
        lost_sync(s, ev, to);
      end
    end else begin
      ev = EV_BAD_ACCEPT;
    end
  endfunction

  function automatic void got_bit(inout hsl_state_t s, inout event_t ev,
                                  inout logic [7:0] evd, input logic b,
                                  input logic [TIMEOUT_W-1:0] to);
    s.rx_shift = ((s.rx_shift == '0) ? RX_MARK : (s.rx_shift >> 1)) | {8'h00, b, 7'h00};
    if (s.rx_shift[8]) begin
      ev = EV_RX;
      evd = s.rx_shift[7:0];
    end else begin
      accept_held(s, ev, to);
    end
  endfunction

  function automatic void on_tip(inout hsl_state_t s, inout event_t ev,
                                 inout logic [7:0] evd, input logic [TIMEOUT_W-1:0] to);
    unique case (s.phase)
      PH_IDLE: begin
        if (!s.tip_seen) begin
          timer_start(s, to);
          s.phase = PH_ACK_0;
          s.ring_out = 1'b0;
        end
      end
      PH_WAIT_ACK_1: begin
        if (!s.tip_seen) begin
          timer_start(s, to);
          s.phase = PH_WAIT_REL_1;
          s.ring_out = 1'b1;
        end
      end
      PH_WAIT_REL_0, PH_HOLD_0: begin
        if (!s.tip_seen) begin
          s.ring_out = 1'b1;
          lost_sync(s, ev, to);
        end
      end
      PH_WAIT_REL_1: begin
        if (s.tip_seen) begin
          start_pending(s, to);
          bit_done(s, ev, to);
        end
      end
      PH_ACK_0: begin
        if (s.tip_seen) begin
          timer_stop(s);
          s.phase = PH_HOLD_0;
          got_bit(s, ev, evd, 1'b0, to);
        end
      end
      PH_WAIT_IDLE: begin
        if (s.tip_seen && s.ring_seen) start_pending(s, to);
      end
      default: ;
    endcase
  endfunction

  function automatic void on_ring(inout hsl_state_t s, inout event_t ev,
                                  inout logic [7:0] evd, input logic [TIMEOUT_W-1:0] to);
    unique case (s.phase)
      PH_IDLE: begin
        if (!s.ring_seen) begin
          timer_start(s, to);
          s.phase = PH_ACK_1;
          s.tip_out = 1'b0;
        end
      end
      PH_WAIT_ACK_0: begin
        if (!s.ring_seen) begin
          timer_start(s, to);
          s.phase = PH_WAIT_REL_0;
          s.tip_out = 1'b1;
        end
      end
      PH_WAIT_REL_0: begin
        if (s.ring_seen) begin
          start_pending(s, to);
          bit_done(s, ev, to);
        end
      end
      PH_WAIT_REL_1, PH_HOLD_1: begin
        if (!s.ring_seen) begin
          s.tip_out = 1'b1;
          lost_sync(s, ev, to);
        end
      end
      PH_ACK_1: begin
        if (s.ring_seen) begin
          timer_stop(s);
          s.phase = PH_HOLD_1;
          got_bit(s, ev, evd, 1'b1, to);
        end
      end
      PH_WAIT_IDLE: begin
        if (s.tip_seen && s.ring_seen) start_pending(s, to);
      end
      default: ;
    endcase
  endfunction

  function automatic void on_timeout(inout hsl_state_t s, inout event_t ev,
                                     input logic [TIMEOUT_W-1:0] to);
    unique case (s.phase)
      PH_ACK_0, PH_ACK_1: begin
        s.tip_out = 1'b1;
        s.ring_out = 1'b1;
        if (s.tip_seen && s.ring_seen) begin
          start_pending(s, to);
        end else begin
          timer_idle_wait(s, to);
          s.phase = PH_WAIT_IDLE;
        end
        s.rx_shift = '0;
        ev = EV_RX_TIMEOUT;
      end
      PH_WAIT_IDLE, PH_WAIT_ACK_0, PH_WAIT_ACK_1, PH_WAIT_REL_0, PH_WAIT_REL_1: begin
        timer_stop(s);
        s.phase = (s.tip_seen && s.ring_seen) ? PH_IDLE : PH_WAIT_IDLE;
        s.pend = PB_EMPTY;
        s.tip_out = 1'b1;
        s.ring_out = 1'b1;
        s.tx_shift = '0;
        ev = EV_TX_TIMEOUT;
      end
      default: begin
        timer_stop(s);
      end
    endcase
  endfunction

  always_comb begin
    hsl_state_t s;
    event_t     ev;
    logic [7:0] evd;
    logic       ovr;
    s   = st;
    ev  = EV_NONE;
    evd = 8'h00;
    ovr = 1'b0;
    unique case (mode_t'(mode))
      MODE_TIP: begin
        if (level != s.tip_seen) begin
          s.tip_seen = level;
          on_tip(s, ev, evd, timeout_ticks);
        end
      end
      MODE_RING: begin
        if (level != s.ring_seen) begin
          s.ring_seen = level;
          on_ring(s, ev, evd, timeout_ticks);
        end
      end
      MODE_SEND: begin
        ovr = (s.tx_shift != '0);
        s.tx_shift = TX_MARK | (tx_data >> 1);
        queue_bit(s, tx_data[0], timeout_ticks);
      end
      MODE_ACCEPT: begin
        if (s.phase == PH_HOLD_0 || s.phase == PH_HOLD_1) s.rx_shift = '0;
        accept_held(s, ev, timeout_ticks);
      end
      MODE_TICK: begin
        if (s.timer_on) begin
          if (s.timer_count <= 24'd1) begin
            timer_stop(s);
            on_timeout(s, ev, timeout_ticks);
          end else begin
            s.timer_count = s.timer_count - 24'd1;
          end
        end
      end
      default: ;
    endcase
    st_next        = s;
    res.tip_drive  = s.tip_out;
    res.ring_drive = s.ring_out;
    res.event_res  = ev;
    res.rx_data    = (ev == EV_RX) ? evd : 8'h00;
    res.overrun    = ovr;
  end

endmodule

/* src/hsl_outq.sv */
// Two-entry result queue: output register plus skid register.
module hsl_outq (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  hsl_pkg::hsl_res_t push_data,
  output logic              full,
  output logic              out_valid,
  input  logic              out_ready,
  output hsl_pkg::hsl_res_t out_data
);
  import hsl_pkg::*;

  hsl_res_t   head;
  hsl_res_t   skid;
  logic [1:0] count;
  logic       pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count != 2'd0);
  assign full      = (count == 2'd2);
  assign out_data  = head;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      unique case (count)
        2'd0: begin
          if (push) count <= 2'd1;
        end
        2'd1: begin
          if (push && !pop) count <= 2'd2;
          else if (!push && pop) count <= 2'd0;
        end
        2'd2: begin
          if (pop) count <= 2'd1;
        end
        default: count <= 2'd0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((count == 2'd0 && push) || (count == 2'd1 && push && pop)) begin
      head <= push_data;
    end else if (count == 2'd2 && pop) begin
      head <= skid;
    end
    if (count == 2'd1 && push && !pop) begin
      skid <= push_data;
    end
  end

endmodule

/* src/two_wire_handshake_byte_link_core.sv */
// Top level of the two-wire handshake byte link.
// Takes one transaction per cycle (line change, send, accept or tick) while
// the result queue is not full, and returns exactly one result transaction
// for each. The whole state update is combinational logic between the link
// state register and a two-entry result queue, so the input side keeps
// taking a transaction every cycle while the result side is ready and may
// run one transaction ahead when it stalls. timeout_ticks resets to 1000000
// and the user must write it through the cfg channel while idle (unchecked).
module two_wire_handshake_byte_link_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // level[0], tx_data[8:1], zero[15:9]
  input  logic [2:0]  s_tuser,   // mode[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // tip_drive[0], ring_drive[1], rx_data[9:2],
                                 // overrun[10], zero[15:11]
  output logic [2:0]  m_tuser,   // event_res[2:0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [23:0] cfg_data   // timeout_ticks[23:0]
);
  import hsl_pkg::*;

  hsl_state_t           st;
  hsl_state_t           st_next;
  hsl_res_t             res;
  hsl_res_t             out_res;
  logic [TIMEOUT_W-1:0] timeout_ticks;
  logic                 q_full;
  logic                 take;

  assign s_tready  = !q_full;
  assign cfg_ready = 1'b1;
  assign take      = s_tvalid && s_tready;

  hsl_step u_step (
    .st            (st),
    .mode          (s_tuser),
    .level         (s_tdata[0]),
    .tx_data       (s_tdata[8:1]),
    .timeout_ticks (timeout_ticks),
    .st_next       (st_next),
    .res           (res)
  );

  hsl_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (take),
    .push_data (res),
    .full      (q_full),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st            <= ST_RESET;
      timeout_ticks <= TIMEOUT_RESET;
    end else begin
      if (take) st <= st_next;
      if (cfg_valid && cfg_ready) timeout_ticks <= cfg_data;
    end
  end

  assign m_tdata = {5'b00000, out_res.overrun, out_res.rx_data,
                    out_res.ring_drive, out_res.tip_drive};
  assign m_tuser = out_res.event_res;

endmodule

/* src/hsl_checker.sv */
// Port-level checks for the link top level, bound into it.
module hsl_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic [2:0]  m_tuser
);
  import hsl_pkg::*;

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result transaction dropped while stalled");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with no result pending");

  a_rx_data_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != EV_RX |-> m_tdata[9:2] == 8'h00)
    else $error("rx_data nonzero without a received byte");

  a_event_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tuser != 3'd7 && m_tdata[15:11] == 5'b00000)
    else $error("bad event code or padding");

endmodule

bind two_wire_handshake_byte_link_core hsl_checker u_hsl_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
